// ----- hdl/qrdp_pkg.sv -----
// ----------------------------------------------------------------------------
// QR data placement package
// Types and constants shared by the QR data module placer and masker.
// ----------------------------------------------------------------------------
package qrdp_pkg;

  localparam int COORD_W           = 8;
  localparam int MAX_ALIGN_CENTERS = 7;
  localparam int ALIGN_W           = COORD_W * MAX_ALIGN_CENTERS;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = ALIGN_W;
  localparam int BIT_CNT_W         = 3;
  localparam int STEP_W            = 17;
  localparam int OUT_DATA_W        = 24;
  localparam int OUT_USER_W        = 2;

  localparam logic [STEP_W-1:0]  WALK_LIMIT   = 17'd65536;
  localparam logic [COORD_W-1:0] RESET_SIZE   = 8'd21;
  localparam logic [COORD_W-1:0] FINDER_EDGE  = 8'd8;
  localparam logic [COORD_W-1:0] TIMING_POS   = 8'd6;
  localparam logic [COORD_W-1:0] VERSION_SPAN = 8'd11;
  localparam logic [COORD_W-1:0] ALIGN_RADIUS = 8'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_PATTERN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERSION_INFO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_COUNT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN_CENTERS = 3'd4;

  typedef enum logic [2:0] {
    MASK_CHECKER    = 3'd0,
    MASK_ROWS       = 3'd1,
    MASK_COLS3      = 3'd2,
    MASK_DIAG3      = 3'd3,
    MASK_BLOCKS     = 3'd4,
    MASK_PROD_SUM   = 3'd5,
    MASK_PROD_PAR   = 3'd6,
    MASK_MIXED_PAR  = 3'd7
  } mask_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WALK = 1'b1
  } state_t;

endpackage

// ----- hdl/qr_data_module_placer_masker.sv -----
// ----------------------------------------------------------------------------
// QR data module placer and masker
// Shifts each codeword byte out one bit per cycle along the QR zigzag, save for
// skipped function modules and output stalls, and emits column, row and masked bit.
// ----------------------------------------------------------------------------
// Timing: a taken byte is held in byte_r, and each of its bits is registered at
// the output once the walk reaches a data module and the output slot is free.
// Throughput: one placement step per cycle while the output is not stalled; a
// byte needs a step for each of its bits and one for every function module the
// walk passes over; the next byte is taken in the cycle its predecessor emits its eighth bit.
// Reset: rst_n is synchronous and active low; it restores the register
// defaults and puts the walk at the bottom-right corner of a 21-module symbol.
module qr_data_module_placer_masker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [qrdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrdp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // data_byte
  input  logic                                 in_tuser,   // start_of_code
  input  logic                                 in_tlast,   // final_byte
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [qrdp_pkg::OUT_DATA_W-1:0]      out_tdata,  // col, row, module_bit, zero fill
  output logic [qrdp_pkg::OUT_USER_W-1:0]      out_tuser,  // dropped, code_done
  output logic                                 out_tlast   // last
);

  localparam int CW = qrdp_pkg::COORD_W;

  logic [CW-1:0]                        size_r;
  qrdp_pkg::mask_t                      mask_r;
  logic                                 vers_r;
  logic [2:0]                           acount_r;
  logic [qrdp_pkg::ALIGN_W-1:0]         centers_r;

  qrdp_pkg::state_t                     state_r, state_nxt;
  logic [CW-1:0]                        col_r, col_nxt;
  logic [CW-1:0]                        row_r, row_nxt;
  logic                                 ended_r, ended_nxt;
  logic [7:0]                           byte_r, byte_nxt;
  logic                                 final_r, final_nxt;
  logic [qrdp_pkg::BIT_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [qrdp_pkg::STEP_W-1:0]          steps_r, steps_nxt;

  logic                                 ov_r;
  logic [CW-1:0]                        ocol_r, orow_r;
  logic                                 obit_r, odrop_r, olast_r, odone_r;

  logic                                 in_fire, slot_ok, emit_req, emit_fire;
  logic                                 emit_drop;
  logic                                 oob, is_func, mask_bit;
  logic [CW-1:0]                        adv_col, adv_row;
  logic [2:0]                           al_use;

  // Remainder by three and the low bit of the quotient for an 8-bit coordinate.
  function automatic logic [2:0] div3(input logic [CW-1:0] v);
    logic [2*CW:0] prod;
    logic [CW-1:0] q;
    logic [CW-1:0] r;
    prod = {1'b0, v} * 17'd171;
    q    = prod[2*CW:9];
    r    = v - CW'(q * 8'd3);
    return {q[0], r[1:0]};
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= qrdp_pkg::RESET_SIZE;
      mask_r    <= qrdp_pkg::MASK_CHECKER;
      vers_r    <= 1'b0;
      acount_r  <= 3'd0;
      centers_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        qrdp_pkg::CFG_SYMBOL_SIZE:   size_r    <= cfg_wdata[CW-1:0];
        qrdp_pkg::CFG_MASK_PATTERN:  mask_r    <= qrdp_pkg::mask_t'(cfg_wdata[2:0]);
        qrdp_pkg::CFG_VERSION_INFO:  vers_r    <= cfg_wdata[0];
        qrdp_pkg::CFG_ALIGN_COUNT:   acount_r  <= cfg_wdata[2:0];
        qrdp_pkg::CFG_ALIGN_CENTERS: centers_r <= cfg_wdata[qrdp_pkg::ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  assign al_use = (acount_r > 3'(qrdp_pkg::MAX_ALIGN_CENTERS)) ?
                  3'(qrdp_pkg::MAX_ALIGN_CENTERS) : acount_r;

  // Function module test for the current walk position.
  always_comb begin
    logic [CW:0]   s9, x9, y9;
    logic [CW+1:0] x10, y10, c10;
    logic [qrdp_pkg::MAX_ALIGN_CENTERS-1:0] xin, yin;
    logic          hit;
    s9  = {1'b0, size_r};
    x9  = {1'b0, col_r};
    y9  = {1'b0, row_r};
    x10 = {2'b0, col_r};
    y10 = {2'b0, row_r};
    hit = 1'b0;
    for (int k = 0; k < qrdp_pkg::MAX_ALIGN_CENTERS; k++) begin
      c10    = {2'b0, centers_r[CW*k +: CW]};
      xin[k] = (x10 <= c10 + 10'(qrdp_pkg::ALIGN_RADIUS)) &&
               (x10 + 10'(qrdp_pkg::ALIGN_RADIUS) >= c10);
      yin[k] = (y10 <= c10 + 10'(qrdp_pkg::ALIGN_RADIUS)) &&
               (y10 + 10'(qrdp_pkg::ALIGN_RADIUS) >= c10);
    end
    for (int a0 = 0; a0 < qrdp_pkg::MAX_ALIGN_CENTERS; a0++) begin
      for (int a1 = 0; a1 < qrdp_pkg::MAX_ALIGN_CENTERS; a1++) begin
        if (a0 < int'(al_use) && a1 < int'(al_use) && xin[a0] && yin[a1] &&
            !(a0 == 0 && a1 == 0) &&
            !(a0 == int'(al_use) - 1 && a1 == 0) &&
            !(a0 == 0 && a1 == int'(al_use) - 1)) begin
          hit = 1'b1;
        end
      end
    end
    is_func = hit ||
      (col_r <= qrdp_pkg::FINDER_EDGE && row_r <= qrdp_pkg::FINDER_EDGE) ||
      (col_r <= qrdp_pkg::FINDER_EDGE && y9 + 9'(qrdp_pkg::FINDER_EDGE) >= s9) ||
      (x9 + 9'(qrdp_pkg::FINDER_EDGE) >= s9 && row_r <= qrdp_pkg::FINDER_EDGE) ||
      (col_r == qrdp_pkg::TIMING_POS) || (row_r == qrdp_pkg::TIMING_POS) ||
      (vers_r && col_r < qrdp_pkg::TIMING_POS &&
       y9 + 9'(qrdp_pkg::VERSION_SPAN) >= s9) ||
      (vers_r && row_r < qrdp_pkg::TIMING_POS &&
       x9 + 9'(qrdp_pkg::VERSION_SPAN) >= s9);
  end

  // Mask value for the current walk position.
  always_comb begin
    logic [2:0] dx, dy;
    logic [2:0] sum3, prd3;
    logic [1:0] sr, pr;
    logic       p1;
    dx   = div3(col_r);
    dy   = div3(row_r);
    sum3 = {1'b0, dx[1:0]} + {1'b0, dy[1:0]};
    prd3 = 3'(dx[1:0] * dy[1:0]);
    sr   = (sum3 >= 3'd3) ? 2'(sum3 - 3'd3) : sum3[1:0];
    pr   = (prd3 >= 3'd3) ? 2'(prd3 - 3'd3) : prd3[1:0];
    p1   = col_r[0] & row_r[0];
    case (mask_r)
      qrdp_pkg::MASK_CHECKER:   mask_bit = ~(col_r[0] ^ row_r[0]);
      qrdp_pkg::MASK_ROWS:      mask_bit = ~row_r[0];
      qrdp_pkg::MASK_COLS3:     mask_bit = (dx[1:0] == 2'd0);
      qrdp_pkg::MASK_DIAG3:     mask_bit = (sr == 2'd0);
      qrdp_pkg::MASK_BLOCKS:    mask_bit = ~(dx[2] ^ row_r[1]);
      qrdp_pkg::MASK_PROD_SUM:  mask_bit = !p1 && (pr == 2'd0);
      qrdp_pkg::MASK_PROD_PAR:  mask_bit = ~(p1 ^ pr[0]);
      qrdp_pkg::MASK_MIXED_PAR: mask_bit = ~(col_r[0] ^ row_r[0] ^ pr[0]);
      default:                  mask_bit = 1'b0;
    endcase
  end

  // Next position along the two-column zigzag.
  always_comb begin
    logic          near_left, down, right_col, at_bottom;
    logic [CW-1:0] sx, dec;
    near_left = (col_r <= qrdp_pkg::TIMING_POS);
    sx        = size_r - col_r - 8'd1;
    down      = near_left ? ~col_r[1] : sx[1];
    right_col = (col_r[0] == near_left);
    at_bottom = ({1'b0, row_r} == ({1'b0, size_r} - 9'd1));
    dec       = col_r - 8'd1;
    adv_col   = dec;
    adv_row   = row_r;
    if (down) begin
      if (!at_bottom && !right_col) begin
        adv_col = col_r + 8'd1;
        adv_row = row_r + 8'd1;
      end
    end else if (row_r != 8'd0) begin
      if (!right_col) begin
        adv_col = col_r + 8'd1;
        adv_row = row_r - 8'd1;
      end
    end else if (dec == qrdp_pkg::TIMING_POS) begin
      adv_col = qrdp_pkg::TIMING_POS - 8'd1;
    end
  end

  assign oob       = (col_r >= size_r) || (row_r >= size_r);
  assign slot_ok   = !ov_r || out_tready;
  assign emit_req  = (state_r == qrdp_pkg::ST_WALK) && (ended_r || oob || !is_func);
  assign emit_drop = ended_r || oob;
  assign emit_fire = emit_req && slot_ok;
  assign in_tready = (state_r == qrdp_pkg::ST_IDLE) ||
                     (emit_fire && cnt_r == qrdp_pkg::BIT_CNT_W'(7));
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ended_nxt = ended_r;
    byte_nxt  = byte_r;
    final_nxt = final_r;
    cnt_nxt   = cnt_r;
    steps_nxt = steps_r;
    if (state_r == qrdp_pkg::ST_WALK) begin
      if (emit_fire) begin
        if (emit_drop) begin
          ended_nxt = 1'b1;
        end else begin
          col_nxt = adv_col;
          row_nxt = adv_row;
        end
        byte_nxt  = {byte_r[6:0], 1'b0};
        cnt_nxt   = cnt_r + qrdp_pkg::BIT_CNT_W'(1);
        steps_nxt = '0;
        if (cnt_r == qrdp_pkg::BIT_CNT_W'(7)) begin
          state_nxt = qrdp_pkg::ST_IDLE;
          if (final_r) begin
            ended_nxt = 1'b1;
          end
        end
      end else if (!emit_req) begin
        if (steps_r == qrdp_pkg::WALK_LIMIT) begin
          ended_nxt = 1'b1;
        end else begin
          steps_nxt = steps_r + qrdp_pkg::STEP_W'(1);
          col_nxt   = adv_col;
          row_nxt   = adv_row;
        end
      end
    end
    if (in_fire) begin
      state_nxt = qrdp_pkg::ST_WALK;
      byte_nxt  = in_tdata;
      final_nxt = in_tlast;
      cnt_nxt   = '0;
      steps_nxt = '0;
      if (in_tuser) begin
        col_nxt   = size_r - 8'd1;
        row_nxt   = size_r - 8'd1;
        ended_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qrdp_pkg::ST_IDLE;
      col_r   <= qrdp_pkg::RESET_SIZE - 8'd1;
      row_r   <= qrdp_pkg::RESET_SIZE - 8'd1;
      ended_r <= 1'b0;
      final_r <= 1'b0;
      cnt_r   <= '0;
      steps_r <= '0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      ended_r <= ended_nxt;
      final_r <= final_nxt;
      cnt_r   <= cnt_nxt;
      steps_r <= steps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit_fire) begin
      ov_r <= 1'b1;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      ocol_r  <= emit_drop ? '0 : col_r;
      orow_r  <= emit_drop ? '0 : row_r;
      obit_r  <= emit_drop ? 1'b0 : (byte_r[7] ^ mask_bit);
      odrop_r <= emit_drop;
      olast_r <= (cnt_r == qrdp_pkg::BIT_CNT_W'(7));
      odone_r <= (cnt_r == qrdp_pkg::BIT_CNT_W'(7)) && final_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {7'b0, obit_r, orow_r, ocol_r};
  assign out_tuser  = {odone_r, odrop_r};
  assign out_tlast  = olast_r;

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[16:0] == 17'd0)
    else $error("dropped bit carries a nonzero position or value");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast)
    else $error("end of code reported before the eighth bit");

  a_take_walk: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == qrdp_pkg::ST_WALK && cnt_r == '0)
    else $error("accepted byte did not start a fresh placement");

  a_idle_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == qrdp_pkg::ST_IDLE |-> cnt_r == '0)
    else $error("bit counter not at zero while idle");

endmodule
